// ===== hw/rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT_LIMIT = 1'b1;

    localparam logic [15:0] TICKS_PER_UNIT_RESET = 16'd1;
    localparam logic [7:0]  ACK_WAIT_LIMIT_RESET = 8'd250;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;
    localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_out;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } out_item_t;

    typedef struct packed {
        logic [15:0] ticks_per_delay_unit;
        logic [7:0]  ack_wait_limit;
    } cfg_t;

endpackage

// ===== hw/rtl/i2cm_cfg.sv =====
`timescale 1ns / 1ps

module i2cm_cfg import i2cm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [15:0] ticks_reg;
    logic [15:0] ticks_next;
    logic [7:0]  limit_reg;
    logic [7:0]  limit_next;

    always_comb
    begin
        ticks_next = ticks_reg;
        limit_next = limit_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_TICKS_PER_UNIT: ticks_next = cfg_data;
                CFG_ACK_WAIT_LIMIT: limit_next = cfg_data[7:0];
                default:
                begin
                    ticks_next = ticks_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= TICKS_PER_UNIT_RESET;
            limit_reg <= ACK_WAIT_LIMIT_RESET;
        end
        else
        begin
            ticks_reg <= ticks_next;
            limit_reg <= limit_next;
        end
    end

    assign cfg.ticks_per_delay_unit = ticks_reg;
    assign cfg.ack_wait_limit       = limit_reg;

endmodule

// ===== hw/rtl/i2cm_seq.sv =====
`timescale 1ns / 1ps

module i2cm_seq import i2cm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    typedef enum logic [14:0] {
        PH_IDLE = 15'b000000000000001,
        PH_S0   = 15'b000000000000010,
        PH_S1   = 15'b000000000000100,
        PH_P0   = 15'b000000000001000,
        PH_P1   = 15'b000000000010000,
        PH_W0   = 15'b000000000100000,
        PH_W1   = 15'b000000001000000,
        PH_W2   = 15'b000000010000000,
        PH_R0   = 15'b000000100000000,
        PH_R1   = 15'b000001000000000,
        PH_A0   = 15'b000010000000000,
        PH_A1   = 15'b000100000000000,
        PH_K0   = 15'b001000000000000,
        PH_K1   = 15'b010000000000000,
        PH_K2   = 15'b100000000000000
    } phase_t;

    phase_t      phase_reg, phase_next, enter_ph;
    logic [3:0]  bc_reg, bc_next, bc_inc;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] delay_reg, delay_next, unit_ticks;
    logic [1:0]  units_reg, units_next;
    logic [7:0]  wait_reg, wait_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        sda_en_reg, sda_en_next;
    logic        ack_reg, ack_next;
    logic [7:0]  read_reg, read_next;
    logic        missing_reg, missing_next;
    logic        done;
    logic        do_enter;

    always_comb
    begin
        phase_next   = phase_reg;
        bc_next      = bc_reg;
        shift_next   = shift_reg;
        delay_next   = delay_reg;
        units_next   = units_reg;
        wait_next    = wait_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        sda_en_next  = sda_en_reg;
        ack_next     = ack_reg;
        read_next    = read_reg;
        missing_next = missing_reg;
        done         = 1'b0;
        do_enter     = 1'b0;
        enter_ph     = PH_IDLE;
        bc_inc       = bc_reg + 4'd1;
        unit_ticks   = (cfg.ticks_per_delay_unit == 16'd0) ? 16'd1 : cfg.ticks_per_delay_unit;

        if (step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (item.command inside {[CMD_START:CMD_WAIT_ACK]})
                    begin
                        bc_next  = '0;
                        do_enter = 1'b1;
                        case (item.command)
                            CMD_START: enter_ph = PH_S0;
                            CMD_STOP:  enter_ph = PH_P0;
                            CMD_WRITE:
                            begin
                                shift_next  = item.write_data;
                                sda_en_next = 1'b1;
                                scl_next    = 1'b0;
                                enter_ph    = PH_W0;
                            end
                            CMD_READ:
                            begin
                                ack_next    = item.send_ack;
                                shift_next  = '0;
                                sda_en_next = 1'b0;
                                enter_ph    = PH_R0;
                            end
                            default:
                            begin
                                missing_next = 1'b0;
                                wait_next    = '0;
                                enter_ph     = PH_K0;
                            end
                        endcase
                    end
                end
                PH_K2:
                begin
                    if (!item.sda_in)
                    begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    else if (wait_reg >= cfg.ack_wait_limit)
                    begin
                        missing_next = 1'b1;
                        do_enter     = 1'b1;
                        enter_ph     = PH_P0;
                    end
                    else
                    begin
                        wait_next = wait_reg + 8'd1;
                    end
                end
                default:
                begin
                    if (delay_reg > 16'd1)
                    begin
                        delay_next = delay_reg - 16'd1;
                    end
                    else if (units_reg > 2'd1)
                    begin
                        units_next = units_reg - 2'd1;
                        delay_next = unit_ticks;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_S0:
                            begin
                                do_enter = 1'b1;
                                enter_ph = PH_S1;
                            end
                            PH_S1:
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            PH_P0:
                            begin
                                do_enter = 1'b1;
                                enter_ph = PH_P1;
                            end
                            PH_W0:
                            begin
                                do_enter = 1'b1;
                                enter_ph = PH_W1;
                            end
                            PH_W1:
                            begin
                                do_enter = 1'b1;
                                enter_ph = PH_W2;
                            end
                            PH_W2:
                            begin
                                bc_next = bc_inc;
                                if (bc_inc >= BITS_PER_BYTE)
                                begin
                                    phase_next = PH_IDLE;
                                    done       = 1'b1;
                                end
                                else
                                begin
                                    do_enter = 1'b1;
                                    enter_ph = PH_W0;
                                end
                            end
                            PH_R0:
                            begin
                                do_enter = 1'b1;
                                enter_ph = PH_R1;
                            end
                            PH_R1:
                            begin
                                bc_next  = bc_inc;
                                do_enter = 1'b1;
                                enter_ph = (bc_inc >= BITS_PER_BYTE) ? PH_A0 : PH_R0;
                            end
                            PH_A0:
                            begin
                                do_enter = 1'b1;
                                enter_ph = PH_A1;
                            end
                            PH_A1:
                            begin
                                scl_next   = 1'b0;
                                read_next  = shift_reg;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            PH_K0:
                            begin
                                do_enter = 1'b1;
                                enter_ph = PH_K1;
                            end
                            PH_K1:
                            begin
                                do_enter = 1'b1;
                                enter_ph = PH_K2;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                        endcase
                    end
                end
            endcase

            if (do_enter)
            begin
                phase_next = enter_ph;
                delay_next = unit_ticks;
                case (enter_ph)
                    PH_S0:
                    begin
                        sda_en_next = 1'b1;
                        sda_next    = 1'b1;
                        scl_next    = 1'b1;
                        units_next  = 2'd2;
                    end
                    PH_S1:
                    begin
                        sda_next   = 1'b0;
                        units_next = 2'd2;
                    end
                    PH_P0:
                    begin
                        sda_en_next = 1'b1;
                        scl_next    = 1'b0;
                        sda_next    = 1'b0;
                        units_next  = 2'd2;
                    end
                    PH_P1:
                    begin
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                        units_next = 2'd2;
                    end
                    PH_W0:
                    begin
                        sda_next   = shift_next[7];
                        shift_next = {shift_next[6:0], 1'b0};
                        units_next = 2'd1;
                    end
                    PH_W1:
                    begin
                        scl_next   = 1'b1;
                        units_next = 2'd1;
                    end
                    PH_W2, PH_R0:
                    begin
                        scl_next   = 1'b0;
                        units_next = 2'd1;
                    end
                    PH_R1:
                    begin
                        scl_next   = 1'b1;
                        shift_next = {shift_next[6:0], item.sda_in};
                        units_next = 2'd1;
                    end
                    PH_A0:
                    begin
                        scl_next    = 1'b0;
                        sda_en_next = 1'b1;
                        sda_next    = ~ack_next;
                        units_next  = 2'd2;
                    end
                    PH_A1:
                    begin
                        scl_next   = 1'b1;
                        units_next = 2'd2;
                    end
                    PH_K0:
                    begin
                        sda_en_next = 1'b0;
                        sda_next    = 1'b1;
                        units_next  = 2'd1;
                    end
                    PH_K1:
                    begin
                        scl_next   = 1'b1;
                        units_next = 2'd1;
                    end
                    default:
                    begin
                        units_next = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bc_reg      <= '0;
            shift_reg   <= '0;
            delay_reg   <= '0;
            units_reg   <= '0;
            wait_reg    <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            sda_en_reg  <= 1'b1;
            ack_reg     <= 1'b0;
            read_reg    <= '0;
            missing_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            bc_reg      <= bc_next;
            shift_reg   <= shift_next;
            delay_reg   <= delay_next;
            units_reg   <= units_next;
            wait_reg    <= wait_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            sda_en_reg  <= sda_en_next;
            ack_reg     <= ack_next;
            read_reg    <= read_next;
            missing_reg <= missing_next;
        end
    end

    assign result.scl_level        = scl_next;
    assign result.sda_out          = sda_next;
    assign result.sda_drive_enable = sda_en_next;
    assign result.busy_res         = (phase_next != PH_IDLE);
    assign result.done_res         = done;
    assign result.read_data        = read_next;
    assign result.ack_missing      = missing_next;

`ifndef SYNTHESIS
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> phase_reg == PH_IDLE)
        else $error("sequence not idle after done");

    a_units_range: assert property (@(posedge clk) disable iff (!rst_n)
        units_reg != 2'd3)
        else $error("unit count out of range");

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bc_reg <= BITS_PER_BYTE)
        else $error("bit counter past byte length");

    a_poll_released: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_K2 |-> !sda_en_reg && scl_reg)
        else $error("ack poll with SDA driven or SCL low");

    a_delay_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE && phase_reg != PH_K2 |-> delay_reg != 16'd0)
        else $error("timed phase with empty delay counter");
`endif

endmodule

// ===== hw/rtl/i2c_bit_level_master_top.sv =====
`timescale 1ns / 1ps

// I2C master line sequencer, one transaction per bus tick.
// Input channel (in_valid/in_stall/in_data): each transaction is one tick with the
// sampled SDA level and, when the sequencer is idle, an optional command (start,
// stop, write byte, read byte with ACK/NACK, wait ACK). Commands given while busy
// are dropped; the busy_res/done_res fields of the results tell when to issue one.
// Output channel (out_valid/out_stall/out_data): exactly one result per input
// transaction with the SCL level, SDA drive value and enable, busy, done pulse,
// last read byte and the ack-missing flag.
// A result is valid once its input transaction has passed the input register and then
// the result register; one transaction is accepted every cycle while the output side
// takes results. The sequencer state advances when a transaction moves from the input
// register into the result register.
// Bus timing counts delay units of ticks_per_delay_unit transactions each (config
// index 0); config index 1 sets the ACK poll limit. Write config only when idle.
// Reset releases the bus high with SDA driven, idles the sequencer and loads the
// register defaults. A stalled output holds its result; the input register then
// fills and in_stall rises, so no transaction is lost.

module i2c_bit_level_master_top import i2cm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic      in_valid_reg, in_valid_next;
    in_item_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;
    out_item_t result;
    cfg_t      cfg;
    logic      move;
    logic      in_take;

    i2cm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cm_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (move),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign move     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !move;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (move)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= in_data;
        end
        if (move)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import i2cm_pkg::*;

    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam int SDA_RANDOM = 0;
    localparam int SDA_LOW    = 1;
    localparam int SDA_HIGH   = 2;

    localparam int MODE_NONE  = 0;
    localparam int MODE_LIGHT = 1;
    localparam int MODE_HEAVY = 2;

    localparam int ITEM_TARGET = 450;

    typedef enum logic [14:0] {
        PH_IDLE         = 15'b000000000000001,
        PH_START_HI     = 15'b000000000000010,
        PH_START_LO     = 15'b000000000000100,
        PH_STOP_LO      = 15'b000000000001000,
        PH_STOP_HI      = 15'b000000000010000,
        PH_WR_DATA      = 15'b000000000100000,
        PH_WR_SCL_HI    = 15'b000000001000000,
        PH_WR_SCL_LO    = 15'b000000010000000,
        PH_RD_SCL_LO    = 15'b000000100000000,
        PH_RD_SCL_HI    = 15'b000001000000000,
        PH_ACK_SETUP    = 15'b000010000000000,
        PH_ACK_SCL_HI   = 15'b000100000000000,
        PH_WAIT_RELEASE = 15'b001000000000000,
        PH_WAIT_SCL_HI  = 15'b010000000000000,
        PH_WAIT_POLL    = 15'b100000000000000
    } seq_phase_t;

    class i2c_line_scoreboard_t;
        logic [15:0] ticks_per_unit;
        logic [7:0]  poll_limit;
        seq_phase_t  phase;
        logic [3:0]  bit_cnt;
        logic [7:0]  shifter;
        logic [15:0] delay_cnt;
        logic [7:0]  units_left;
        logic [7:0]  polls_seen;
        logic        scl;
        logic        sda;
        logic        sda_en;
        logic        ack_sel;
        logic [7:0]  read_byte;
        logic        missing;
        out_item_t   expected_lines[$];
        int          errors;
        int          results;

        function new();
            ticks_per_unit = TICKS_PER_UNIT_RESET;
            poll_limit     = ACK_WAIT_LIMIT_RESET;
            phase          = PH_IDLE;
            bit_cnt        = '0;
            shifter        = '0;
            delay_cnt      = '0;
            units_left     = '0;
            polls_seen     = '0;
            scl            = 1'b1;
            sda            = 1'b1;
            sda_en         = 1'b1;
            ack_sel        = 1'b0;
            read_byte      = '0;
            missing        = 1'b0;
            errors         = 0;
            results        = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_TICKS_PER_UNIT)
                ticks_per_unit = value;
            else if (idx == CFG_ACK_WAIT_LIMIT)
                poll_limit = value[7:0];
        endfunction

        function bit busy();
            return phase != PH_IDLE;
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        // a zero unit length counts as one tick
        function void hold(logic [7:0] n);
            delay_cnt  = (ticks_per_unit == 16'd0) ? 16'd1 : ticks_per_unit;
            units_left = n;
        endfunction

        function void enter(seq_phase_t ph, logic sda_now);
            phase = ph;
            case (ph)
                PH_START_HI:
                begin
                    sda_en = 1'b1;
                    sda = 1'b1;
                    scl = 1'b1;
                    hold(8'd2);
                end
                PH_START_LO:
                begin
                    sda = 1'b0;
                    hold(8'd2);
                end
                PH_STOP_LO:
                begin
                    sda_en = 1'b1;
                    scl = 1'b0;
                    sda = 1'b0;
                    hold(8'd2);
                end
                PH_STOP_HI:
                begin
                    scl = 1'b1;
                    sda = 1'b1;
                    hold(8'd2);
                end
                PH_WR_DATA:
                begin
                    sda = shifter[7];
                    shifter = {shifter[6:0], 1'b0};
                    hold(8'd1);
                end
                PH_WR_SCL_HI:
                begin
                    scl = 1'b1;
                    hold(8'd1);
                end
                PH_WR_SCL_LO, PH_RD_SCL_LO:
                begin
                    scl = 1'b0;
                    hold(8'd1);
                end
                PH_RD_SCL_HI:
                begin
                    scl = 1'b1;
                    shifter = {shifter[6:0], sda_now};
                    hold(8'd1);
                end
                PH_ACK_SETUP:
                begin
                    scl = 1'b0;
                    sda_en = 1'b1;
                    sda = ~ack_sel;
                    hold(8'd2);
                end
                PH_ACK_SCL_HI:
                begin
                    scl = 1'b1;
                    hold(8'd2);
                end
                PH_WAIT_RELEASE:
                begin
                    sda_en = 1'b0;
                    sda = 1'b1;
                    hold(8'd1);
                end
                PH_WAIT_SCL_HI:
                begin
                    scl = 1'b1;
                    hold(8'd1);
                end
                default:
                    hold(8'd0);
            endcase
        endfunction

        // current step has run out; returns 1 when the sequence is over
        function bit advance(logic sda_now);
            case (phase)
                PH_START_HI:
                begin
                    enter(PH_START_LO, sda_now);
                    return 1'b0;
                end
                PH_START_LO:
                    scl = 1'b0;
                PH_STOP_LO:
                begin
                    enter(PH_STOP_HI, sda_now);
                    return 1'b0;
                end
                PH_WR_DATA:
                begin
                    enter(PH_WR_SCL_HI, sda_now);
                    return 1'b0;
                end
                PH_WR_SCL_HI:
                begin
                    enter(PH_WR_SCL_LO, sda_now);
                    return 1'b0;
                end
                PH_WR_SCL_LO:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < BITS_PER_BYTE)
                    begin
                        enter(PH_WR_DATA, sda_now);
                        return 1'b0;
                    end
                end
                PH_RD_SCL_LO:
                begin
                    enter(PH_RD_SCL_HI, sda_now);
                    return 1'b0;
                end
                PH_RD_SCL_HI:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= BITS_PER_BYTE)
                        enter(PH_ACK_SETUP, sda_now);
                    else
                        enter(PH_RD_SCL_LO, sda_now);
                    return 1'b0;
                end
                PH_ACK_SETUP:
                begin
                    enter(PH_ACK_SCL_HI, sda_now);
                    return 1'b0;
                end
                PH_ACK_SCL_HI:
                begin
                    scl = 1'b0;
                    read_byte = shifter;
                end
                PH_WAIT_RELEASE:
                begin
                    enter(PH_WAIT_SCL_HI, sda_now);
                    return 1'b0;
                end
                PH_WAIT_SCL_HI:
                begin
                    enter(PH_WAIT_POLL, sda_now);
                    return 1'b0;
                end
                default:
                    ;
            endcase
            phase = PH_IDLE;
            return 1'b1;
        endfunction

        function void take_tick(in_item_t it);
            out_item_t e;
            bit        done;
            done = 1'b0;
            if (phase == PH_IDLE)
            begin
                case (it.command)
                    CMD_START:
                    begin
                        bit_cnt = '0;
                        enter(PH_START_HI, it.sda_in);
                    end
                    CMD_STOP:
                    begin
                        bit_cnt = '0;
                        enter(PH_STOP_LO, it.sda_in);
                    end
                    CMD_WRITE:
                    begin
                        bit_cnt = '0;
                        shifter = it.write_data;
                        sda_en = 1'b1;
                        scl = 1'b0;
                        enter(PH_WR_DATA, it.sda_in);
                    end
                    CMD_READ:
                    begin
                        bit_cnt = '0;
                        ack_sel = it.send_ack;
                        shifter = '0;
                        sda_en = 1'b0;
                        enter(PH_RD_SCL_LO, it.sda_in);
                    end
                    CMD_WAIT_ACK:
                    begin
                        bit_cnt = '0;
                        missing = 1'b0;
                        polls_seen = '0;
                        enter(PH_WAIT_RELEASE, it.sda_in);
                    end
                    default:
                        ;
                endcase
            end
            else if (phase == PH_WAIT_POLL)
            begin
                if (!it.sda_in)
                begin
                    scl = 1'b0;
                    phase = PH_IDLE;
                    done = 1'b1;
                end
                else if (polls_seen >= poll_limit)
                begin
                    missing = 1'b1;
                    enter(PH_STOP_LO, it.sda_in);
                end
                else
                    polls_seen = polls_seen + 8'd1;
            end
            else if (delay_cnt > 16'd1)
                delay_cnt = delay_cnt - 16'd1;
            else if (units_left > 8'd1)
            begin
                units_left = units_left - 8'd1;
                hold(units_left);
            end
            else
                done = advance(it.sda_in);

            e.scl_level        = scl;
            e.sda_out          = sda;
            e.sda_drive_enable = sda_en;
            e.busy_res         = (phase != PH_IDLE);
            e.done_res         = done;
            e.read_data        = read_byte;
            e.ack_missing      = missing;
            expected_lines.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50)
                $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        task check_lines(out_item_t got);
            out_item_t e;
            results++;
            if (expected_lines.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", results));
                return;
            end
            e = expected_lines.pop_front();
            if (got.scl_level !== e.scl_level)
                report($sformatf("result %0d scl_level got %0b exp %0b",
                                 results, got.scl_level, e.scl_level));
            if (got.sda_out !== e.sda_out)
                report($sformatf("result %0d sda_out got %0b exp %0b",
                                 results, got.sda_out, e.sda_out));
            if (got.sda_drive_enable !== e.sda_drive_enable)
                report($sformatf("result %0d sda_drive_enable got %0b exp %0b",
                                 results, got.sda_drive_enable, e.sda_drive_enable));
            if (got.busy_res !== e.busy_res)
                report($sformatf("result %0d busy_res got %0b exp %0b",
                                 results, got.busy_res, e.busy_res));
            if (got.done_res !== e.done_res)
                report($sformatf("result %0d done_res got %0b exp %0b",
                                 results, got.done_res, e.done_res));
            if (got.read_data !== e.read_data)
                report($sformatf("result %0d read_data got %02h exp %02h",
                                 results, got.read_data, e.read_data));
            if (got.ack_missing !== e.ack_missing)
                report($sformatf("result %0d ack_missing got %0b exp %0b",
                                 results, got.ack_missing, e.ack_missing));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    i2c_line_scoreboard_t lines = new();

    int tx_mode = MODE_NONE;
    int rx_mode = MODE_NONE;
    int burst_left = 0;
    int stall_left = 0;
    int items_sent = 0;

    i2c_bit_level_master_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (rx_mode != MODE_NONE &&
                 $urandom_range(0, 99) < ((rx_mode == MODE_LIGHT) ? 10 : 35))
        begin
            stall_left = $urandom_range(0, (rx_mode == MODE_LIGHT) ? 2 : 7);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            lines.check_lines(out_data);
    end

    function logic line_level(int mode);
        if (mode == SDA_LOW)
            return 1'b0;
        if (mode == SDA_HIGH)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    // called and returns at a falling edge
    task send_tick(in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (tx_mode == MODE_NONE) ? 0 :
                  $urandom_range(0, (tx_mode == MODE_LIGHT) ? 2 : 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        lines.take_tick(item);
        items_sent++;
        @(negedge clk);
    endtask

    // issues one command while idle, then ticks until the sequence is over
    task run_command(logic [2:0] cmd, logic [7:0] data, logic ack, int sda_mode,
                     int high_polls);
        in_item_t item;
        int       polls;
        polls = 0;
        item.command    = cmd;
        item.write_data = data;
        item.send_ack   = ack;
        item.sda_in     = line_level(sda_mode);
        send_tick(item);
        while (lines.busy())
        begin
            item.command    = 3'($urandom_range(0, 7));
            item.write_data = 8'($urandom);
            item.send_ack   = 1'($urandom_range(0, 1));
            if (lines.phase == PH_WAIT_POLL)
            begin
                item.sda_in = (polls < high_polls);
                polls++;
            end
            else
                item.sda_in = line_level(sda_mode);
            send_tick(item);
        end
    endtask

    task wait_for_ack();
        run_command(CMD_WAIT_ACK, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM,
                    ($urandom_range(0, 9) == 0) ? int'(lines.poll_limit) + 1 :
                                                  int'($urandom_range(0, 3)));
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        in_valid <= 1'b0;
        while (lines.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        lines.set_reg(idx, value);
        @(negedge clk);
        cfg_write <= 1'b0;
        burst_left = 0;
    endtask

    task bus_transfer();
        int i;
        int n;
        bit rd;
        n  = $urandom_range(1, 2);
        rd = $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0)
            run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)),
                        SDA_RANDOM, int'($urandom_range(0, 3)));
        run_command(CMD_START, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM, 0);
        run_command(CMD_WRITE, {7'($urandom), rd}, 1'($urandom_range(0, 1)), SDA_RANDOM, 0);
        wait_for_ack();
        for (i = 0; i < n && !lines.missing && items_sent < ITEM_TARGET; i++)
        begin
            if (rd)
                run_command(CMD_READ, 8'($urandom), (i != n - 1), SDA_RANDOM, 0);
            else
            begin
                run_command(CMD_WRITE, 8'($urandom), 1'($urandom_range(0, 1)),
                            SDA_RANDOM, 0);
                wait_for_ack();
            end
        end
        // aborted transfers already ended in a stop
        if (!lines.missing && $urandom_range(0, 15) != 0)
            run_command(CMD_STOP, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RANDOM, 0);
        repeat ($urandom_range(0, 3))
            run_command(($urandom_range(0, 1) != 0) ? CMD_NONE : CMD_RSVD6, 8'($urandom),
                        1'($urandom_range(0, 1)), SDA_RANDOM, 0);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_command(CMD_NONE, 8'h00, 1'b0, SDA_LOW, 0);
        run_command(CMD_RSVD6, 8'hFF, 1'b1, SDA_HIGH, 0);
        run_command(CMD_RSVD7, 8'hFF, 1'b1, SDA_LOW, 0);
        run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
        run_command(CMD_WRITE, 8'h00, 1'b0, SDA_LOW, 0);
        run_command(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, 0);
        run_command(CMD_WRITE, 8'hFF, 1'b1, SDA_HIGH, 0);
        run_command(CMD_WAIT_ACK, 8'hFF, 1'b1, SDA_RANDOM, 3);
        run_command(CMD_READ, 8'h00, 1'b1, SDA_LOW, 0);
        run_command(CMD_READ, 8'hFF, 1'b0, SDA_HIGH, 0);
        run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);

        tx_mode = MODE_LIGHT;
        rx_mode = MODE_LIGHT;
        write_reg(CFG_ACK_WAIT_LIMIT, 16'h0000);
        run_command(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, 1);
        run_command(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, 0);
        write_reg(CFG_ACK_WAIT_LIMIT, 16'h0001);
        run_command(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, 1);
        run_command(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, 2);
        write_reg(CFG_ACK_WAIT_LIMIT, 16'h00FF);
        run_command(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, 3);
        write_reg(CFG_TICKS_PER_UNIT, 16'h0000);
        run_command(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 0);
        run_command(CMD_WRITE, 8'h3C, 1'b0, SDA_RANDOM, 0);
        run_command(CMD_READ, 8'h00, 1'b0, SDA_RANDOM, 0);
        run_command(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
        write_reg(CFG_TICKS_PER_UNIT, 16'd4);
        run_command(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_RANDOM, 0);

        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_TICKS_PER_UNIT, 16'd0);
                1, 2:    write_reg(CFG_TICKS_PER_UNIT, 16'd1);
                default: write_reg(CFG_TICKS_PER_UNIT, 16'd2);
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_ACK_WAIT_LIMIT, {8'($urandom), 8'd0});
                1:       write_reg(CFG_ACK_WAIT_LIMIT, {8'($urandom), 8'd1});
                default: write_reg(CFG_ACK_WAIT_LIMIT,
                                   {8'($urandom), 8'($urandom_range(2, 6))});
            endcase
            tx_mode = $urandom_range(MODE_NONE, MODE_HEAVY);
            rx_mode = $urandom_range(MODE_NONE, MODE_HEAVY);
            bus_transfer();
        end

        in_valid <= 1'b0;
        while (lines.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (lines.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("ERROR: timeout with %0d transactions outstanding", lines.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
